@@ rtl/ljc_pkg.sv @@
package ljc_pkg;

  localparam int IFRAC  = 32;
  localparam int OUT_W  = 48;
  localparam int QDEPTH = 4;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SUM_MIN = -SUM_MAX;
  localparam logic signed [63:0] SIX_ONE    = 64'sh0000_0006_0000_0000;
  localparam logic signed [63:0] TWELVE_ONE = 64'sh0000_000C_0000_0000;
  localparam logic [47:0] OUT_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] OUT_MIN = 48'h8000_0000_0000;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef logic signed [63:0] s64_t;

  typedef struct packed {
    logic zero;
    s64_t a;
    s64_t b;
    s64_t q;
  } coef_t;

  typedef struct packed {
    coef_t       c;
    logic [31:0] x;
  } in_pkt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic zero;
    logic sat;
    s64_t a;
    s64_t b;
    s64_t q;
    s64_t ir;
    s64_t inv_r;
    s64_t p1;
    s64_t coul;
    s64_t b6;
    s64_t ir6;
    s64_t cir;
    s64_t ta;
    s64_t disp;
    s64_t e1;
    s64_t f1;
    s64_t energy;
    s64_t m1;
    s64_t force_v;
  } ctx_t;

  typedef struct packed {
    logic sat;
    s64_t val;
  } sres_t;

  typedef struct packed {
    logic        sat;
    logic [47:0] val;
  } ores_t;

  // Saturating add, limited to +-(2^63 - 1).
  function automatic sres_t sadd(s64_t a, s64_t b);
    logic signed [64:0] s;
    sres_t r;
    s = {a[63], a} + {b[63], b};
    if (s > SUM_MAX) begin
      r.sat = 1'b1;
      r.val = S64_MAX;
    end else if (s < SUM_MIN) begin
      r.sat = 1'b1;
      r.val = -S64_MAX;
    end else begin
      r.sat = 1'b0;
      r.val = s[63:0];
    end
    return r;
  endfunction

  // Truncate toward zero to 24 fraction bits and clamp to 48 bits.
  function automatic ores_t to_out(s64_t v);
    logic [63:0] mg;
    logic [55:0] m;
    ores_t r;
    mg = v[63] ? 64'(-v) : 64'(v);
    m = mg[63:8];
    r.sat = 1'b0;
    if (v[63]) begin
      if (m > 56'(OUT_MIN)) begin
        r.sat = 1'b1;
        r.val = OUT_MIN;
      end else begin
        r.val = 48'(~m[47:0] + 48'd1);
      end
    end else begin
      if (m > 56'(OUT_MAX)) begin
        r.sat = 1'b1;
        r.val = OUT_MAX;
      end else begin
        r.val = m[47:0];
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/ljc_if.sv @@
interface ljc_in_if;
  logic               valid;
  logic               ready;
  logic        [31:0] dist_sq;
  logic signed [31:0] repulsion_coef;
  logic signed [31:0] dispersion_coef;
  logic signed [31:0] charge_product;

  modport source (output valid, dist_sq, repulsion_coef, dispersion_coef, charge_product,
                  input ready);
  modport sink (input valid, dist_sq, repulsion_coef, dispersion_coef, charge_product,
                output ready);
endinterface

interface ljc_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] pair_energy;
  logic signed [47:0] coulomb_energy;
  logic signed [47:0] force_factor;
  logic        [1:0]  status;

  modport source (output valid, pair_energy, coulomb_energy, force_factor, status,
                  input ready);
  modport sink (input valid, pair_energy, coulomb_energy, force_factor, status,
                output ready);
endinterface

@@ rtl/ljc_front.sv @@
module ljc_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  ljc_in_if.sink           in_ch,
  input  ljc_pkg::qstat_t  qs,
  output logic             push,
  output ljc_pkg::in_pkt_t pkt
);
  import ljc_pkg::*;

  localparam int SH = IFRAC - FRAC_BITS;

  logic    fv_r, fv_nxt, acc;
  in_pkt_t pk_r;

  assign in_ch.ready = !fv_r || !qs.full;
  assign acc  = in_ch.valid && in_ch.ready;
  assign push = fv_r && !qs.full;
  assign pkt  = pk_r;

  always_comb begin
    fv_nxt = fv_r;
    if (acc) begin
      fv_nxt = 1'b1;
    end else if (push) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  // Classify zero distance and widen coefficients to 32 fraction bits.
  always_ff @(posedge clk) begin
    if (acc) begin
      pk_r.x      <= in_ch.dist_sq;
      pk_r.c.zero <= (in_ch.dist_sq == 32'd0);
      pk_r.c.a    <= 64'(in_ch.repulsion_coef) <<< SH;
      pk_r.c.b    <= 64'(in_ch.dispersion_coef) <<< SH;
      pk_r.c.q    <= 64'(in_ch.charge_product) <<< SH;
    end
  end
endmodule

@@ rtl/ljc_queue.sv @@
module ljc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ljc_pkg::in_pkt_t din,
  input  logic             pop,
  output ljc_pkg::in_pkt_t dout,
  output ljc_pkg::qstat_t  qs
);
  import ljc_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  in_pkt_t       ent_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign qs.full  = (cnt_r == (PW+1)'(QDEPTH));
  assign qs.empty = (cnt_r == '0);
  assign do_push  = push && !qs.full;
  assign do_pop   = pop && !qs.empty;
  assign dout     = ent_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= din;
    end
  end
endmodule

@@ rtl/ljc_divsqrt.sv @@
module ljc_divsqrt #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  ljc_pkg::in_pkt_t in_pk,
  output logic             out_v,
  output ljc_pkg::ctx_t    out_ctx
);
  import ljc_pkg::*;

  localparam int NB = 2 * IFRAC + FRAC_BITS;
  localparam int QW = NB + 1;
  localparam int SW = (QW + 1) / 2;
  localparam int NW = 2 * SW;
  localparam int RW = SW + 3;

  // Restoring division of 2^NB by dist_sq, one quotient bit per stage.
  logic          dv_r  [QW];
  logic [31:0]   rem_r [QW];
  logic [QW-1:0] quo_r [QW];
  in_pkt_t       dpk_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic          v_in, ge;
    logic [31:0]   rem_in;
    logic [QW-1:0] quo_in;
    in_pkt_t       pk_in;
    logic [32:0]   r1;

    if (i == 0) begin : g_first
      assign v_in   = in_v;
      assign rem_in = '0;
      assign quo_in = '0;
      assign pk_in  = in_pk;
    end else begin : g_next
      assign v_in   = dv_r[i-1];
      assign rem_in = rem_r[i-1];
      assign quo_in = quo_r[i-1];
      assign pk_in  = dpk_r[i-1];
    end

    assign r1 = {rem_in, 1'(i == 0)};
    assign ge = (r1 >= {1'b0, pk_in.x});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[i] <= 1'b0;
      end else if (en) begin
        dv_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? 32'(r1 - {1'b0, pk_in.x}) : r1[31:0];
        quo_r[i] <= {quo_in[QW-2:0], ge};
        dpk_r[i] <= pk_in;
      end
    end
  end

  // Restoring square root of the quotient, one root bit per stage.
  logic          sv_r   [SW];
  logic [RW-1:0] srem_r [SW];
  logic [SW-1:0] root_r [SW];
  logic [NW-1:0] sn_r   [SW];
  s64_t          sir_r  [SW];
  coef_t         sc_r   [SW];

  for (genvar j = 0; j < SW; j++) begin : g_sqrt
    logic          v_in, ge;
    logic [RW-1:0] rem_in, r1, trial;
    logic [SW-1:0] root_in;
    logic [NW-1:0] n_in;
    s64_t          ir_in;
    coef_t         c_in;

    if (j == 0) begin : g_first
      assign v_in    = dv_r[QW-1];
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = NW'(quo_r[QW-1]);
      assign ir_in   = 64'(quo_r[QW-1] >> IFRAC);
      assign c_in    = dpk_r[QW-1].c;
    end else begin : g_next
      assign v_in    = sv_r[j-1];
      assign rem_in  = srem_r[j-1];
      assign root_in = root_r[j-1];
      assign n_in    = sn_r[j-1];
      assign ir_in   = sir_r[j-1];
      assign c_in    = sc_r[j-1];
    end

    assign r1    = {rem_in[RW-3:0], n_in[NW-1:NW-2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (r1 >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[j] <= 1'b0;
      end else if (en) begin
        sv_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        srem_r[j] <= ge ? (r1 - trial) : r1;
        root_r[j] <= {root_in[SW-2:0], ge};
        sn_r[j]   <= {n_in[NW-3:0], 2'b00};
        sir_r[j]  <= ir_in;
        sc_r[j]   <= c_in;
      end
    end
  end

  assign out_v = sv_r[SW-1];

  always_comb begin
    out_ctx       = '0;
    out_ctx.zero  = sc_r[SW-1].zero;
    out_ctx.a     = sc_r[SW-1].a;
    out_ctx.b     = sc_r[SW-1].b;
    out_ctx.q     = sc_r[SW-1].q;
    out_ctx.ir    = sir_r[SW-1];
    out_ctx.inv_r = 64'(root_r[SW-1]);
  end
endmodule

@@ rtl/ljc_fmul.sv @@
module ljc_fmul (
  input  logic                clk,
  input  logic                en,
  input  logic signed [63:0]  a,
  input  logic signed [63:0]  b,
  output logic signed [63:0]  res_r,
  output logic                sat_r
);
  import ljc_pkg::*;

  logic [63:0]  ma, mb, m;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic         neg_r, sat;
  logic [127:0] p;

  assign ma = a[63] ? 64'(-a) : 64'(a);
  assign mb = b[63] ? 64'(-b) : 64'(b);

  // Four 32x32 partial products, then combine and drop 32 fraction bits.
  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= ma[31:0] * mb[31:0];
      p01_r <= ma[31:0] * mb[63:32];
      p10_r <= ma[63:32] * mb[31:0];
      p11_r <= ma[63:32] * mb[63:32];
      neg_r <= a[63] ^ b[63];
    end
  end

  assign p = {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0} + {p11_r, 64'd0};
  assign sat = |p[127:95];
  assign m = sat ? 64'(S64_MAX) : p[95:32];

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= neg_r ? 64'(-m) : m;
      sat_r <= sat;
    end
  end
endmodule

@@ rtl/ljc_arith.sv @@
module ljc_arith (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_v,
  input  ljc_pkg::ctx_t ctx_in,
  output logic          adv,
  ljc_out_if.source     out_ch
);
  import ljc_pkg::*;

  localparam int NL = 6;
  localparam int NM = 11;
  localparam int MLEV [NM] = '{0, 0, 0, 1, 1, 2, 2, 3, 3, 4, 5};

  ctx_t src [NL];
  ctx_t mg  [NL];
  ctx_t d1_r [NL];
  ctx_t d2_r [NL];
  ctx_t lv_r [NL];
  logic v1_r [NL];
  logic v2_r [NL];
  logic vl_r [NL];

  s64_t fa [NM];
  s64_t fb [NM];
  s64_t fr [NM];
  logic fs [NM];

  logic               ov_r;
  logic signed [47:0] pe_r, ce_r, ff_r;
  status_t            st_r;

  assign adv = !ov_r || out_ch.ready;

  always_comb begin
    src[0] = ctx_in;
    for (int l = 1; l < NL; l++) begin
      src[l] = lv_r[l-1];
    end
  end

  always_comb begin
    fa[0]  = src[MLEV[0]].ir;    fb[0]  = src[MLEV[0]].ir;
    fa[1]  = src[MLEV[1]].q;     fb[1]  = src[MLEV[1]].inv_r;
    fa[2]  = src[MLEV[2]].b;     fb[2]  = SIX_ONE;
    fa[3]  = src[MLEV[3]].p1;    fb[3]  = src[MLEV[3]].ir;
    fa[4]  = src[MLEV[4]].coul;  fb[4]  = src[MLEV[4]].ir;
    fa[5]  = src[MLEV[5]].a;     fb[5]  = src[MLEV[5]].ir6;
    fa[6]  = src[MLEV[6]].b;     fb[6]  = src[MLEV[6]].ir6;
    fa[7]  = src[MLEV[7]].ta;    fb[7]  = src[MLEV[7]].ir6;
    fa[8]  = src[MLEV[8]].ta;    fb[8]  = TWELVE_ONE;
    fa[9]  = src[MLEV[9]].f1;    fb[9]  = src[MLEV[9]].ir6;
    fa[10] = src[MLEV[10]].m1;   fb[10] = src[MLEV[10]].ir;
  end

  for (genvar m = 0; m < NM; m++) begin : g_mul
    ljc_fmul u_fmul (
      .clk   (clk),
      .en    (adv),
      .a     (fa[m]),
      .b     (fb[m]),
      .res_r (fr[m]),
      .sat_r (fs[m])
    );
  end

  // Each level merges the delayed context with its products and sums.
  always_comb begin
    sres_t s0, s1;
    for (int l = 0; l < NL; l++) begin
      mg[l] = d2_r[l];
    end
    mg[0].p1   = fr[0];
    mg[0].coul = fr[1];
    mg[0].b6   = fr[2];
    mg[0].sat  = d2_r[0].sat | fs[0] | fs[1] | fs[2];
    mg[1].ir6  = fr[3];
    mg[1].cir  = fr[4];
    mg[1].sat  = d2_r[1].sat | fs[3] | fs[4];
    mg[2].ta   = fr[5];
    mg[2].disp = fr[6];
    mg[2].sat  = d2_r[2].sat | fs[5] | fs[6];
    s0 = sadd(fr[7], -d2_r[3].disp);
    s1 = sadd(d2_r[3].b6, -fr[8]);
    mg[3].e1   = s0.val;
    mg[3].f1   = s1.val;
    mg[3].sat  = d2_r[3].sat | fs[7] | fs[8] | s0.sat | s1.sat;
    s0 = sadd(d2_r[4].e1, d2_r[4].coul);
    mg[4].energy = s0.val;
    mg[4].m1     = fr[9];
    mg[4].sat    = d2_r[4].sat | fs[9] | s0.sat;
    s1 = sadd(fr[10], -d2_r[5].cir);
    mg[5].force_v = s1.val;
    mg[5].sat     = d2_r[5].sat | fs[10] | s1.sat;
  end

  for (genvar l = 0; l < NL; l++) begin : g_lev
    logic v_in;
    if (l == 0) begin : g_first
      assign v_in = in_v;
    end else begin : g_next
      assign v_in = vl_r[l-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v1_r[l] <= 1'b0;
        v2_r[l] <= 1'b0;
        vl_r[l] <= 1'b0;
      end else if (adv) begin
        v1_r[l] <= v_in;
        v2_r[l] <= v1_r[l];
        vl_r[l] <= v2_r[l];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d1_r[l] <= src[l];
        d2_r[l] <= d1_r[l];
        lv_r[l] <= mg[l];
      end
    end
  end

  // Output register: final truncation, clamping and status.
  always_ff @(posedge clk) begin
    ores_t oe, oc, of;
    oe = to_out(lv_r[NL-1].energy);
    oc = to_out(lv_r[NL-1].coul);
    of = to_out(lv_r[NL-1].force_v);
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= vl_r[NL-1];
      if (lv_r[NL-1].zero) begin
        pe_r <= '0;
        ce_r <= '0;
        ff_r <= '0;
        st_r <= ST_ZERO;
      end else begin
        pe_r <= oe.val;
        ce_r <= oc.val;
        ff_r <= of.val;
        st_r <= (lv_r[NL-1].sat | oe.sat | oc.sat | of.sat) ? ST_SAT : ST_OK;
      end
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.pair_energy    = pe_r;
  assign out_ch.coulomb_energy = ce_r;
  assign out_ch.force_factor   = ff_r;
  assign out_ch.status         = st_r;
endmodule

@@ rtl/lj_coulomb_pair_kernel.sv @@
// Lennard-Jones 12-6 plus Coulomb pair kernel.
// The in_ch channel carries one atom pair per transaction: the squared
// distance and the pair's repulsion, dispersion and charge coefficients.
// The out_ch channel returns one transaction per pair with the pair energy,
// the Coulomb energy, the scalar force factor and a status code (ok,
// saturated, zero distance), always in input order.
// Throughput is one pair per clock cycle while the receiver keeps ready
// high. The pipelined reciprocal divider (FRAC_BITS + 65 stages, one
// quotient bit per stage) and the square root (one root bit per stage)
// make up most of the pipeline. Six multiply levels of three stages
// follow; the queue write and the output register complete it.
// After reset all pipeline stages and the queue are empty and no result is
// pending. When the receiver holds ready low the result stays on out_ch and
// the whole back pipeline holds; the small queue and the input register
// keep accepting until they fill, then in_ch ready drops.
module lj_coulomb_pair_kernel #(
  parameter int FRAC_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  ljc_in_if.sink    in_ch,
  ljc_out_if.source out_ch
);
  import ljc_pkg::*;

  qstat_t  qs;
  logic    push, pop, adv, ds_v;
  in_pkt_t f_pkt, q_pkt;
  ctx_t    ds_ctx;

  // Front end: registers each transaction and flags a zero distance.
  ljc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .qs    (qs),
    .push  (push),
    .pkt   (f_pkt)
  );

  // Decoupling queue between the front end and the arithmetic pipeline.
  ljc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (f_pkt),
    .pop   (pop),
    .dout  (q_pkt),
    .qs    (qs)
  );

  // The back pipeline takes a pair whenever it advances and one is queued.
  assign pop = adv && !qs.empty;

  ljc_divsqrt #(.FRAC_BITS(FRAC_BITS)) u_divsqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_v    (pop),
    .in_pk   (q_pkt),
    .out_v   (ds_v),
    .out_ctx (ds_ctx)
  );

  ljc_arith u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_v   (ds_v),
    .ctx_in (ds_ctx),
    .adv    (adv),
    .out_ch (out_ch)
  );
endmodule
